### hdl/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

	// Queue geometry
	localparam int DEPTH   = 64;
	localparam int KEY_W   = 32;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int ENTRY_W = 7;
	localparam int OP_W    = 2;
	localparam int ST_W    = 2;

	// Operation codes of an input transaction
	localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
	localparam logic [OP_W-1:0] OP_POP    = 2'd1;
	localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;

	// Result status codes
	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

	// Commands broadcast to every cell of the row
	localparam logic [1:0] CMD_NOP    = 2'd0;
	localparam logic [1:0] CMD_PUSH   = 2'd1;
	localparam logic [1:0] CMD_POP    = 2'd2;
	localparam logic [1:0] CMD_REMOVE = 2'd3;

	typedef logic signed [KEY_W-1:0] key_t;

	typedef struct packed {
		logic [1:0] code;
		key_t       key;
	} cell_cmd_t;

	// What a cell shows to its neighbors
	typedef struct packed {
		key_t key;
		logic valid;
		logic gt;
	} cell_link_t;

endpackage

### hdl/spq_cell.sv
`timescale 1ns / 1ps

module spq_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  spq_pkg::cell_cmd_t     cmd,
	input  spq_pkg::cell_link_t    left,
	input  spq_pkg::cell_link_t    right,
	output spq_pkg::cell_link_t    link,
	output logic                   eq,
	output spq_pkg::key_t          nxt_key,
	output logic                   nxt_valid
);

	spq_pkg::key_t key_q;
	logic          valid_q;
	logic          gt;

	// Compare the held key against the broadcast key
	assign gt = valid_q && ($signed(key_q) > $signed(cmd.key));
	assign eq = valid_q && (key_q == cmd.key);

	assign link.key   = key_q;
	assign link.valid = valid_q;
	assign link.gt    = gt;

	// Keep, take the broadcast key, or shift from a neighbor
	always_comb begin
		nxt_key   = key_q;
		nxt_valid = valid_q;
		case (cmd.code)
			spq_pkg::CMD_PUSH: begin
				if (!gt) begin
					if (left.gt) begin
						nxt_key   = cmd.key;
						nxt_valid = 1'b1;
					end else begin
						nxt_key   = left.key;
						nxt_valid = left.valid;
					end
				end
			end
			spq_pkg::CMD_POP: begin
				nxt_key   = right.key;
				nxt_valid = right.valid;
			end
			spq_pkg::CMD_REMOVE: begin
				if (!gt) begin
					nxt_key   = right.key;
					nxt_valid = right.valid;
				end
			end
			default: begin
				nxt_key   = key_q;
				nxt_valid = valid_q;
			end
		endcase
	end

	// Occupancy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt_valid;
		end
	end

	// Key storage
	always_ff @(posedge clk) begin
		key_q <= nxt_key;
	end

endmodule

### hdl/sorted_priority_queue.sv
`timescale 1ns / 1ps
// Push, pop, no-op and a modify whose old key is not found run in the EXEC state; the result
// is registered as EXEC ends. A modify that finds its old key runs a remove pass in EXEC, then
// an insert pass in INS, and its result is registered as INS ends. A new transaction is taken
// only in IDLE with the result register free; the row of cells updates once per pass.
// Reset clears the sequencer state, the count, every cell's occupancy flag and the result
// valid flag; stored keys and result fields are not reset.

module sorted_priority_queue (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [spq_pkg::OP_W-1:0]            opcode,
	input  logic signed [spq_pkg::KEY_W-1:0]    new_key,
	input  logic signed [spq_pkg::KEY_W-1:0]    old_key,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [spq_pkg::KEY_W-1:0]    front_key,
	output logic                                front_valid,
	output logic [spq_pkg::ENTRY_W-1:0]         entry_count,
	output logic [spq_pkg::ST_W-1:0]            status
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_INS  = 2'd2;

	logic [1:0]                    state_q;
	logic [1:0]                    state_d;
	logic [spq_pkg::OP_W-1:0]      op_q;
	spq_pkg::key_t                 new_key_q;
	spq_pkg::key_t                 old_key_q;
	logic [spq_pkg::CNT_W-1:0]     count_q;
	logic [spq_pkg::CNT_W-1:0]     count_d;

	spq_pkg::cell_cmd_t            cmd;
	spq_pkg::cell_link_t           link [spq_pkg::DEPTH];
	spq_pkg::cell_link_t           left_in [spq_pkg::DEPTH];
	spq_pkg::cell_link_t           right_in [spq_pkg::DEPTH];
	logic [spq_pkg::DEPTH-1:0]     eq_vec;
	spq_pkg::key_t                 nxt_key [spq_pkg::DEPTH];
	logic [spq_pkg::DEPTH-1:0]     nxt_valid;

	logic                          done;
	logic [spq_pkg::ST_W-1:0]      status_d;
	logic                          full;
	logic                          empty;
	logic                          found;
	logic                          accept;

	logic                          out_valid_q;
	spq_pkg::key_t                 front_key_q;
	logic                          front_valid_q;
	logic [spq_pkg::ENTRY_W-1:0]   entry_count_q;
	logic [spq_pkg::ST_W-1:0]      status_q;

	assign full   = (count_q == spq_pkg::CNT_W'(spq_pkg::DEPTH));
	assign empty  = (count_q == '0);
	assign found  = |eq_vec;
	assign accept = in_valid && in_ready;

	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);

	// Build the chain of cells
	genvar gi;
	generate
		for (gi = 0; gi < spq_pkg::DEPTH; gi++) begin : g_cell
			if (gi == 0) begin : g_head
				assign left_in[gi] = '{key: '0, valid: 1'b1, gt: 1'b1};
			end else begin : g_mid_l
				assign left_in[gi] = link[gi-1];
			end
			if (gi == spq_pkg::DEPTH - 1) begin : g_tail
				assign right_in[gi] = '{key: '0, valid: 1'b0, gt: 1'b0};
			end else begin : g_mid_r
				assign right_in[gi] = link[gi+1];
			end
			spq_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.cmd       (cmd),
				.left      (left_in[gi]),
				.right     (right_in[gi]),
				.link      (link[gi]),
				.eq        (eq_vec[gi]),
				.nxt_key   (nxt_key[gi]),
				.nxt_valid (nxt_valid[gi])
			);
		end
	endgenerate

	// Sequence the cell commands for the held transaction
	always_comb begin
		cmd      = '{code: spq_pkg::CMD_NOP, key: new_key_q};
		state_d  = state_q;
		count_d  = count_q;
		done     = 1'b0;
		status_d = spq_pkg::ST_OK;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				done    = 1'b1;
				state_d = S_IDLE;
				case (op_q)
					spq_pkg::OP_PUSH: begin
						if (full) begin
							status_d = spq_pkg::ST_FULL;
						end else begin
							cmd.code = spq_pkg::CMD_PUSH;
							count_d  = count_q + 1'b1;
						end
					end
					spq_pkg::OP_POP: begin
						if (empty) begin
							status_d = spq_pkg::ST_EMPTY;
						end else begin
							cmd.code = spq_pkg::CMD_POP;
							count_d  = count_q - 1'b1;
						end
					end
					spq_pkg::OP_MODIFY: begin
						cmd.key = old_key_q;
						if (found) begin
							cmd.code = spq_pkg::CMD_REMOVE;
							count_d  = count_q - 1'b1;
							done     = 1'b0;
							state_d  = S_INS;
						end else begin
							status_d = spq_pkg::ST_NOTFOUND;
						end
					end
					default: begin
						status_d = spq_pkg::ST_OK;
					end
				endcase
			end
			S_INS: begin
				cmd.code = spq_pkg::CMD_PUSH;
				count_d  = count_q + 1'b1;
				done     = 1'b1;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	// Capture the transaction payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= opcode;
			new_key_q <= new_key;
			old_key_q <= old_key;
		end
	end

	// Hold the result until the consumer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			front_key_q   <= nxt_valid[0] ? nxt_key[0] : spq_pkg::key_t'(-1);
			front_valid_q <= nxt_valid[0];
			entry_count_q <= spq_pkg::ENTRY_W'(count_d);
			status_q      <= status_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign front_key   = front_key_q;
	assign front_valid = front_valid_q;
	assign entry_count = entry_count_q;
	assign status      = status_q;

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;

	// Unused opcode: the block reports its current state and changes nothing
	localparam logic [spq_pkg::OP_W-1:0] OP_NOP = 2'd3;
	localparam spq_pkg::key_t KEY_MAX = 32'sh7FFF_FFFF;
	localparam spq_pkg::key_t KEY_MIN = 32'sh8000_0000;
	localparam int MAX_REPORTS = 20;

	typedef struct {
		spq_pkg::key_t               front;
		logic                        fvalid;
		logic [spq_pkg::ENTRY_W-1:0] count;
		logic [spq_pkg::ST_W-1:0]    st;
	} queue_result_t;

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_ready;
	logic [spq_pkg::OP_W-1:0]    opcode;
	spq_pkg::key_t               new_key;
	spq_pkg::key_t               old_key;
	logic                        out_valid;
	logic                        out_ready;
	spq_pkg::key_t               front_key;
	logic                        front_valid;
	logic [spq_pkg::ENTRY_W-1:0] entry_count;
	logic [spq_pkg::ST_W-1:0]    status;

	// Predicted queue contents, largest key first
	spq_pkg::key_t prio_keys[$];
	queue_result_t pending_results[$];

	int send_idle_pct;
	int recv_stall_pct;
	int err_count;
	int ops_sent;
	int results_seen;
	int peak_count;
	int status_seen[4];

	sorted_priority_queue dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.new_key     (new_key),
		.old_key     (old_key),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.front_key   (front_key),
		.front_valid (front_valid),
		.entry_count (entry_count),
		.status      (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("tb failed");
		$finish;
	end

	// Insert ahead of the first key that is not greater, so a new key goes ahead of equal keys
	function automatic void insert_key(spq_pkg::key_t k);
		int pos;
		pos = 0;
		while (pos < prio_keys.size() && prio_keys[pos] > k)
			pos++;
		prio_keys.insert(pos, k);
	endfunction

	function automatic queue_result_t apply_queue_op(logic [spq_pkg::OP_W-1:0] op,
			spq_pkg::key_t nk, spq_pkg::key_t ok);
		queue_result_t r;
		int pos;
		r.st = spq_pkg::ST_OK;
		case (op)
			spq_pkg::OP_PUSH: begin
				if (prio_keys.size() >= spq_pkg::DEPTH)
					r.st = spq_pkg::ST_FULL;
				else
					insert_key(nk);
			end
			spq_pkg::OP_POP: begin
				if (prio_keys.size() == 0)
					r.st = spq_pkg::ST_EMPTY;
				else
					prio_keys.delete(0);
			end
			spq_pkg::OP_MODIFY: begin
				// Remove first, so a modify on a full queue always fits
				pos = 0;
				while (pos < prio_keys.size() && prio_keys[pos] != ok)
					pos++;
				if (pos >= prio_keys.size()) begin
					r.st = spq_pkg::ST_NOTFOUND;
				end else begin
					prio_keys.delete(pos);
					insert_key(nk);
				end
			end
			default: begin
			end
		endcase
		r.fvalid = (prio_keys.size() > 0);
		r.front  = r.fvalid ? prio_keys[0] : -32'sd1;
		r.count  = spq_pkg::ENTRY_W'(prio_keys.size());
		status_seen[r.st]++;
		if (prio_keys.size() > peak_count)
			peak_count = prio_keys.size();
		return r;
	endfunction

	// Small keys half the time so that ties and modify hits are frequent
	function automatic spq_pkg::key_t pick_key();
		int sel;
		sel = $urandom_range(99);
		if (sel < 50)
			return spq_pkg::key_t'($urandom_range(16)) - 32'sd8;
		if (sel < 60) begin
			case ($urandom_range(3))
				0: return KEY_MIN;
				1: return KEY_MAX;
				2: return -32'sd1;
				default: return 32'sd0;
			endcase
		end
		return spq_pkg::key_t'($urandom);
	endfunction

	function automatic spq_pkg::key_t pick_old_key();
		if (prio_keys.size() > 0 && $urandom_range(99) < 75)
			return prio_keys[$urandom_range(prio_keys.size() - 1)];
		return pick_key();
	endfunction

	function automatic spq_pkg::key_t rnd_key();
		return spq_pkg::key_t'($urandom);
	endfunction

	// Send one transaction; called at a rising edge, returns at the accepting edge
	task automatic send_op(logic [spq_pkg::OP_W-1:0] op, spq_pkg::key_t nk,
			spq_pkg::key_t ok);
		int gap;
		bit rdy;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		new_key  <= nk;
		old_key  <= ok;
		// Sample ready mid-cycle, where it is settled until the next edge
		do begin
			@(negedge clk);
			rdy = in_ready;
			@(posedge clk);
		end while (!rdy);
		pending_results.push_back(apply_queue_op(op, nk, ok));
		ops_sent++;
	endtask

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			if (err_count < MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			err_count++;
		end
	endtask

	// Drive the result side ready with the configured stall rate
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Check each result transaction against the oldest prediction
	always @(negedge clk) begin : result_check
		queue_result_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				if (err_count < MAX_REPORTS)
					$display("%0t: unexpected result, expected none, actual front %0d status %0d",
						$time, front_key, status);
				err_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("front_key", want.front, front_key);
				check_field("front_valid", want.fvalid, front_valid);
				check_field("entry_count", want.count, entry_count);
				check_field("status", want.st, status);
			end
		end
	end

	// Extremes, ties, every opcode and every status but full on a short queue
	task automatic test_directed();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_op(spq_pkg::OP_POP, rnd_key(), rnd_key());
		send_op(spq_pkg::OP_MODIFY, 32'sd5, 32'sd0);
		send_op(OP_NOP, rnd_key(), rnd_key());
		send_op(spq_pkg::OP_PUSH, KEY_MAX, rnd_key());
		send_op(spq_pkg::OP_PUSH, KEY_MIN, rnd_key());
		send_op(spq_pkg::OP_PUSH, -32'sd1, rnd_key());
		send_op(spq_pkg::OP_PUSH, 32'sd0, rnd_key());
		send_op(spq_pkg::OP_PUSH, -32'sd1, rnd_key());
		send_op(spq_pkg::OP_PUSH, 32'sd1, rnd_key());
		send_op(spq_pkg::OP_PUSH, KEY_MAX, rnd_key());
		send_op(OP_NOP, rnd_key(), rnd_key());
		send_op(spq_pkg::OP_MODIFY, KEY_MAX, -32'sd1);
		send_op(spq_pkg::OP_MODIFY, 32'sd7, 32'sd12345);
		send_op(spq_pkg::OP_MODIFY, KEY_MIN, KEY_MIN);
		send_op(spq_pkg::OP_MODIFY, -32'sd2, 32'sd0);
		repeat (8) send_op(spq_pkg::OP_POP, rnd_key(), rnd_key());
	endtask

	// Fill to capacity, overflow, modify while full, then drain past empty
	task automatic test_fill_overflow();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		while (prio_keys.size() < spq_pkg::DEPTH)
			send_op(spq_pkg::OP_PUSH, pick_key(), rnd_key());
		send_op(spq_pkg::OP_PUSH, KEY_MAX, rnd_key());
		send_op(spq_pkg::OP_PUSH, pick_key(), rnd_key());
		send_op(OP_NOP, rnd_key(), rnd_key());
		send_op(spq_pkg::OP_MODIFY, pick_key(),
			prio_keys[$urandom_range(spq_pkg::DEPTH - 1)]);
		send_op(spq_pkg::OP_MODIFY, KEY_MIN, prio_keys[0]);
		send_op(spq_pkg::OP_MODIFY, pick_key(), rnd_key());
		while (prio_keys.size() > 0)
			send_op(spq_pkg::OP_POP, rnd_key(), rnd_key());
		send_op(spq_pkg::OP_POP, rnd_key(), rnd_key());
	endtask

	// Random mix: grow the queue in the first half, shrink it in the second
	task automatic test_random_mix(int n, int idle_pct, int stall_pct);
		int push_pct;
		int pop_pct;
		int sel;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < n; i++) begin
			push_pct = (i < n / 2) ? 70 : 20;
			pop_pct  = (i < n / 2) ? 10 : 50;
			sel = $urandom_range(99);
			if (sel < push_pct)
				send_op(spq_pkg::OP_PUSH, pick_key(), rnd_key());
			else if (sel < push_pct + pop_pct)
				send_op(spq_pkg::OP_POP, rnd_key(), rnd_key());
			else if (sel < 95)
				send_op(spq_pkg::OP_MODIFY, pick_key(), pick_old_key());
			else
				send_op(OP_NOP, rnd_key(), rnd_key());
		end
	endtask

	initial begin
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		opcode   <= spq_pkg::OP_PUSH;
		new_key  <= '0;
		old_key  <= '0;
		err_count    = 0;
		ops_sent     = 0;
		results_seen = 0;
		peak_count   = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_overflow();
		test_random_mix(160, 0, 0);
		test_random_mix(160, 48, 0);
		test_random_mix(160, 0, 48);
		test_random_mix(160, 15, 15);
		in_valid <= 1'b0;

		// Wait for outstanding results, then watch for strays
		while (pending_results.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("%0d operations sent, %0d results checked, peak occupancy %0d of %0d",
			ops_sent, results_seen, peak_count, spq_pkg::DEPTH);
		$display("status mix: ok %0d, full %0d, empty %0d, not found %0d",
			status_seen[spq_pkg::ST_OK], status_seen[spq_pkg::ST_FULL],
			status_seen[spq_pkg::ST_EMPTY], status_seen[spq_pkg::ST_NOTFOUND]);
		if (err_count == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
